// ----- design/canrx_pkg.sv -----
// ----------------------------------------------------------------------------
// canrx_pkg
// Shared types and constants for the CAN frame receive FIFO.
// ----------------------------------------------------------------------------
package canrx_pkg;

   localparam int ID_W     = 29;
   localparam int LEN_W    = 4;
   localparam int DATA_W   = 64;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int HELD_W   = 8;
   localparam int ENTRY_W  = ID_W + LEN_W + DATA_W;

   localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

   // request opcodes
   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FETCH
   } ctl_state_type;

   typedef struct packed {
      logic capture;     // latch request fields
      logic do_push;     // write slot, bump count
      logic do_pop;      // read slot, drop count
      logic do_clear;    // zero the peak
      logic load_exec;   // load response from execute step
      logic load_fetch;  // load response from RAM read data
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
   } dp_stat_type;

endpackage

// ----- design/canrx_ram.sv -----
// ----------------------------------------------------------------------------
// canrx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module canrx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/canrx_dp.sv -----
// ----------------------------------------------------------------------------
// canrx_dp
// Datapath: request capture, frame store, pointers, counters, response regs.
// ----------------------------------------------------------------------------
module canrx_dp
   import canrx_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  logic [OP_W-1:0]     req_op,
   input  logic [ID_W-1:0]     req_frame_id,
   input  logic [LEN_W-1:0]    req_frame_len,
   input  logic [DATA_W-1:0]   req_frame_data,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_out_id,
   output logic [LEN_W-1:0]    rsp_out_len,
   output logic [DATA_W-1:0]   rsp_out_data,
   output logic [HELD_W-1:0]   rsp_frames_held,
   output logic                rsp_frames_waiting,
   output logic [HELD_W-1:0]   rsp_peak_held
);

   localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);

   // captured request
   logic [OP_W-1:0]   op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [DATA_W-1:0] data_ff;
   logic [LEN_W-1:0]  len_clamp;
   logic [DATA_W-1:0] data_masked;

   // queue state
   logic [SLOT_W-1:0] wr_slot_ff, wr_slot_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  peak_ff, peak_in;
   logic [STATUS_W-1:0] status_c;

   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [ENTRY_W-1:0] ram_rd_data;

   // response registers
   logic [STATUS_W-1:0] status_ff;
   logic [ID_W-1:0]     out_id_ff;
   logic [LEN_W-1:0]    out_len_ff;
   logic [DATA_W-1:0]   out_data_ff;
   logic [HELD_W-1:0]   held_ff;
   logic                waiting_ff;
   logic [HELD_W-1:0]   peak_held_ff;

   // clamp length and zero bytes at or past it
   always_comb begin
      len_clamp = (req_frame_len > MAX_LEN) ? MAX_LEN : req_frame_len;
      for (int i = 0; i < 8; i++) begin
         data_masked[i*8 +: 8] = (LEN_W'(i) < len_clamp) ? req_frame_data[i*8 +: 8] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         id_ff   <= req_frame_id;
         len_ff  <= len_clamp;
         data_ff <= data_masked;
      end
   end

   assign stat.op    = op_ff;
   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_slot_in = wr_slot_ff;
      rd_slot_in = rd_slot_ff;
      count_in   = count_ff;
      peak_in    = peak_ff;
      ram_wr_en  = 1'b0;
      ram_rd_en  = 1'b0;
      if (cmd.do_push) begin
         ram_wr_en  = 1'b1;
         wr_slot_in = (wr_slot_ff == LAST_SLOT) ? '0 : wr_slot_ff + 1'b1;
         count_in   = count_ff + 1'b1;
         if (count_in > peak_ff) begin
            peak_in = count_in;
         end
      end
      if (cmd.do_pop) begin
         ram_rd_en  = 1'b1;
         rd_slot_in = (rd_slot_ff == LAST_SLOT) ? '0 : rd_slot_ff + 1'b1;
         count_in   = count_ff - 1'b1;
      end
      if (cmd.do_clear) begin
         peak_in = '0;
      end
   end

   always_comb begin
      unique case (op_ff)
         OP_PUSH: status_c = stat.full ? STAT_FULL : STAT_OK;
         OP_POP:  status_c = stat.empty ? STAT_EMPTY : STAT_OK;
         default: status_c = STAT_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff <= '0;
         rd_slot_ff <= '0;
         count_ff   <= '0;
         peak_ff    <= '0;
      end else begin
         wr_slot_ff <= wr_slot_in;
         rd_slot_ff <= rd_slot_in;
         count_ff   <= count_in;
         peak_ff    <= peak_in;
      end
   end

   canrx_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_slot_ff),
      .wr_data ({id_ff, len_ff, data_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_slot_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_exec) begin
         status_ff    <= status_c;
         out_id_ff    <= '0;
         out_len_ff   <= '0;
         out_data_ff  <= '0;
         held_ff      <= HELD_W'(count_in);
         waiting_ff   <= (count_in != '0);
         peak_held_ff <= HELD_W'(peak_in);
      end else if (cmd.load_fetch) begin
         status_ff    <= STAT_OK;
         out_id_ff    <= ram_rd_data[ENTRY_W-1 -: ID_W];
         out_len_ff   <= ram_rd_data[DATA_W +: LEN_W];
         out_data_ff  <= ram_rd_data[DATA_W-1:0];
         held_ff      <= HELD_W'(count_ff);
         waiting_ff   <= (count_ff != '0);
         peak_held_ff <= HELD_W'(peak_ff);
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_out_id         = out_id_ff;
   assign rsp_out_len        = out_len_ff;
   assign rsp_out_data       = out_data_ff;
   assign rsp_frames_held    = held_ff;
   assign rsp_frames_waiting = waiting_ff;
   assign rsp_peak_held      = peak_held_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("occupancy above queue depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cmd.do_push && !cmd.do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not raise occupancy");
`endif

endmodule

// ----- design/canrx_ctrl.sv -----
// ----------------------------------------------------------------------------
// canrx_ctrl
// Controller: request/response handshake and execute sequencing.
// ----------------------------------------------------------------------------
module canrx_ctrl
   import canrx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   // response register can take a new value this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               unique case (stat.op)
                  OP_PUSH: begin
                     cmd.do_push   = !stat.full;
                     cmd.load_exec = 1'b1;
                     rsp_valid_in  = 1'b1;
                  end
                  OP_POP: begin
                     if (stat.empty) begin
                        cmd.load_exec = 1'b1;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        cmd.do_pop = 1'b1;
                        state_in   = S_FETCH;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.do_clear  = 1'b1;
                     cmd.load_exec = 1'b1;
                     rsp_valid_in  = 1'b1;
                  end
                  default: begin
                     cmd.load_exec = 1'b1;
                     rsp_valid_in  = 1'b1;
                  end
               endcase
            end
         end
         S_FETCH: begin
            // RAM data is ready; response register was emptied in execute
            cmd.load_fetch = 1'b1;
            rsp_valid_in   = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_fetch_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |-> !rsp_valid_ff)
      else $error("fetch with response register still occupied");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.do_push |-> !stat.full)
      else $error("push issued on full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.do_pop |-> !stat.empty)
      else $error("pop issued on empty queue");

   a_no_lost_rsp: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_exec || cmd.load_fetch) |-> out_free)
      else $error("response overwritten before delivery");
`endif

endmodule

// ----- design/can_frame_receive_fifo.sv -----
// ----------------------------------------------------------------------------
// can_frame_receive_fifo
// Circular receive queue of CAN frames with occupancy high-water mark.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): op selects push, pop or clear of the peak mark;
//   push carries identifier, length code and eight data bytes. Length codes
//   above 8 are clamped to 8 and bytes at or past the length are stored as 0.
//   Response channel (rsp_*): exactly one response per request, in order,
//   with status, popped frame (zero unless a pop succeeded), occupancy,
//   frames-waiting flag and peak occupancy after the request.
//   Timing: a request is taken in idle and runs in execute once the response
//   register is free; push, clear and failed pops load the response there,
//   while a successful pop reads the frame store in execute and loads the
//   registered read data in fetch. A new request is taken only after the
//   idle/execute/fetch sequence of the controller has returned to idle.
//   A response waiting in the output register does not block accepting the
//   next request; that request holds in execute until the response is taken.
//   Reset clears pointers, occupancy and peak; the frame store is not
//   cleared, and the block accepts requests as soon as reset is released.
// ----------------------------------------------------------------------------
module can_frame_receive_fifo
   import canrx_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_op,
   input  logic [ID_W-1:0]     req_frame_id,
   input  logic [LEN_W-1:0]    req_frame_len,
   input  logic [DATA_W-1:0]   req_frame_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_out_id,
   output logic [LEN_W-1:0]    rsp_out_len,
   output logic [DATA_W-1:0]   rsp_out_data,
   output logic [HELD_W-1:0]   rsp_frames_held,
   output logic                rsp_frames_waiting,
   output logic [HELD_W-1:0]   rsp_peak_held
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencing and handshake
   canrx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // frame store, pointers, counters and response register
   canrx_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_op             (req_op),
      .req_frame_id       (req_frame_id),
      .req_frame_len      (req_frame_len),
      .req_frame_data     (req_frame_data),
      .rsp_status         (rsp_status),
      .rsp_out_id         (rsp_out_id),
      .rsp_out_len        (rsp_out_len),
      .rsp_out_data       (rsp_out_data),
      .rsp_frames_held    (rsp_frames_held),
      .rsp_frames_waiting (rsp_frames_waiting),
      .rsp_peak_held      (rsp_peak_held)
   );

endmodule
